// File: rtl/iee_pkg.sv
`timescale 1ns / 1ps

package iee_pkg;

    // Node kinds held on the stack
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_NUM   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLUS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMES = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PAREN = 2'd3;

    // Value width and stack entry layout {kind, value}
    localparam int VAL_W   = 64;
    localparam int HALF_W  = VAL_W / 2;
    localparam int ENTRY_W = KIND_W + VAL_W;

    // Characters that act
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_TIMES = 8'h2A;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expression;
    } in_t;

    typedef struct packed {
        logic [VAL_W-1:0] expr_value;
        logic [VAL_W-1:0] running_total;
        logic             error;
    } out_t;

endpackage

// File: rtl/infix_expression_evaluator.sv
`timescale 1ns / 1ps
// Operators and '(' push straight from idle; a digit folds through FOLD0 and, as needed, FOLD1 and FOLD2.
// ')' and line end pop one node at a time and multiply each number in
// (one 32x32 multiplier takes three partial products and a sum per node).
// A line end then waits in EMIT to hand the result to the output register.
// One character is in work at a time. Reset clears depth, total and error;
// stack RAM contents are not cleared and need no clearing pass.

module infix_expression_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  iee_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output iee_pkg::out_t m_payload
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    // Sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FOLD0   = 4'd1;
    localparam logic [3:0] ST_FOLD1   = 4'd2;
    localparam logic [3:0] ST_FOLD2   = 4'd3;
    localparam logic [3:0] ST_MUL_POP = 4'd4;
    localparam logic [3:0] ST_MUL_CHK = 4'd5;
    localparam logic [3:0] ST_MUL_P0  = 4'd6;
    localparam logic [3:0] ST_MUL_P1  = 4'd7;
    localparam logic [3:0] ST_MUL_P2  = 4'd8;
    localparam logic [3:0] ST_MUL_SUM = 4'd9;
    localparam logic [3:0] ST_EMIT    = 4'd10;

    localparam int HW = iee_pkg::HALF_W;
    localparam int VW = iee_pkg::VAL_W;
    localparam int KW = iee_pkg::KIND_W;

    logic [3:0]    state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          err_reg, err_next;
    logic [VW-1:0] total_reg, total_next;
    logic [VW-1:0] val_reg, val_next;
    logic [VW-1:0] prod_reg, prod_next;
    logic [VW-1:0] opnd_reg, opnd_next;
    logic [VW-1:0] pp0_reg, pp0_next;
    logic [HW-1:0] pp1_reg, pp1_next;
    logic [HW-1:0] pp2_reg, pp2_next;
    logic          last_reg, last_next;
    logic          close_reg, close_next;
    logic          m_valid_reg, m_valid_next;
    iee_pkg::out_t m_payload_reg, m_payload_next;

    // Stack RAM ports
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [iee_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [iee_pkg::ENTRY_W-1:0] ram_rdata;
    logic [KW-1:0]              rd_kind;
    logic [VW-1:0]              rd_value;

    // Shared multiplier
    logic [HW-1:0] mul_a, mul_b;
    logic [VW-1:0] mul_p;

    // Sequencer requests resolved after the state case
    logic          push_req;
    logic [KW-1:0] push_kind;
    logic [VW-1:0] push_val;
    logic          char_done;
    logic          mul_done;
    logic          mul_paren;
    logic          out_free;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;

    iee_ram #(
        .WIDTH (iee_pkg::ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_kind  = ram_rdata[iee_pkg::ENTRY_W-1 -: KW];
    assign rd_value = ram_rdata[VW-1:0];
    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);

    // Multiplier operand selection: low x low, low x high, high x low
    always_comb begin
        unique case (state_reg)
            ST_MUL_P1: begin
                mul_a = prod_reg[HW-1:0];
                mul_b = opnd_reg[VW-1:HW];
            end
            ST_MUL_P2: begin
                mul_a = prod_reg[VW-1:HW];
                mul_b = opnd_reg[HW-1:0];
            end
            default: begin
                mul_a = prod_reg[HW-1:0];
                mul_b = opnd_reg[HW-1:0];
            end
        endcase
    end

    assign mul_p = VW'(mul_a) * VW'(mul_b);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        total_next     = total_reg;
        val_next       = val_reg;
        prod_next      = prod_reg;
        opnd_next      = opnd_reg;
        pp0_next       = pp0_reg;
        pp1_next       = pp1_reg;
        pp2_next       = pp2_reg;
        last_next      = last_reg;
        close_next     = close_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        ram_we         = 1'b0;
        ram_waddr      = depth_reg[AW-1:0];
        ram_wdata      = '0;
        ram_raddr      = depth_m1[AW-1:0];
        push_req       = 1'b0;
        push_kind      = iee_pkg::KIND_NUM;
        push_val       = '0;
        char_done      = 1'b0;
        mul_done       = 1'b0;
        mul_paren      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next = s_payload.end_of_expression;
                    if (s_payload.char_code >= iee_pkg::CHAR_ZERO &&
                        s_payload.char_code <= iee_pkg::CHAR_NINE) begin
                        val_next   = VW'(s_payload.char_code - iee_pkg::CHAR_ZERO);
                        state_next = ST_FOLD0;
                    end else if (s_payload.char_code == iee_pkg::CHAR_PLUS) begin
                        push_req  = 1'b1;
                        push_kind = iee_pkg::KIND_PLUS;
                        char_done = 1'b1;
                    end else if (s_payload.char_code == iee_pkg::CHAR_TIMES) begin
                        push_req  = 1'b1;
                        push_kind = iee_pkg::KIND_TIMES;
                        char_done = 1'b1;
                    end else if (s_payload.char_code == iee_pkg::CHAR_OPEN) begin
                        push_req  = 1'b1;
                        push_kind = iee_pkg::KIND_PAREN;
                        char_done = 1'b1;
                    end else if (s_payload.char_code == iee_pkg::CHAR_CLOSE) begin
                        prod_next  = VW'(1);
                        close_next = 1'b1;
                        state_next = ST_MUL_POP;
                    end else begin
                        char_done = 1'b1;
                    end
                end
            end
            // Fold: look at the top node
            ST_FOLD0: begin
                if (depth_reg == '0) begin
                    push_req  = 1'b1;
                    push_val  = val_reg;
                    char_done = 1'b1;
                end else begin
                    state_next = ST_FOLD1;
                end
            end
            ST_FOLD1: begin
                priority if (rd_kind == iee_pkg::KIND_PAREN ||
                             rd_kind == iee_pkg::KIND_TIMES) begin
                    push_req  = 1'b1;
                    push_val  = val_reg;
                    char_done = 1'b1;
                end else if (rd_kind == iee_pkg::KIND_NUM) begin
                    err_next  = 1'b1;
                    char_done = 1'b1;
                end else begin
                    // Drop the pending plus, then check the node under it
                    depth_next = depth_m1;
                    if (depth_m1 == '0) begin
                        err_next  = 1'b1;
                        push_req  = 1'b1;
                        push_val  = val_reg;
                        char_done = 1'b1;
                    end else begin
                        ram_raddr  = depth_m2[AW-1:0];
                        state_next = ST_FOLD2;
                    end
                end
            end
            ST_FOLD2: begin
                if (rd_kind != iee_pkg::KIND_NUM) begin
                    err_next = 1'b1;
                    push_req = 1'b1;
                    push_val = val_reg;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = depth_m1[AW-1:0];
                    ram_wdata = {iee_pkg::KIND_NUM, rd_value + val_reg};
                end
                char_done = 1'b1;
            end
            // Multiply out: pop one node, read issued at the old top
            ST_MUL_POP: begin
                if (depth_reg == '0) begin
                    mul_done = 1'b1;
                end else begin
                    depth_next = depth_m1;
                    state_next = ST_MUL_CHK;
                end
            end
            ST_MUL_CHK: begin
                unique case (rd_kind)
                    iee_pkg::KIND_PAREN: begin
                        mul_done  = 1'b1;
                        mul_paren = 1'b1;
                    end
                    iee_pkg::KIND_NUM: begin
                        opnd_next  = rd_value;
                        state_next = ST_MUL_P0;
                    end
                    iee_pkg::KIND_PLUS: begin
                        err_next   = 1'b1;
                        state_next = ST_MUL_POP;
                    end
                    default: begin
                        state_next = ST_MUL_POP;
                    end
                endcase
            end
            ST_MUL_P0: begin
                pp0_next   = mul_p;
                state_next = ST_MUL_P1;
            end
            ST_MUL_P1: begin
                pp1_next   = mul_p[HW-1:0];
                state_next = ST_MUL_P2;
            end
            ST_MUL_P2: begin
                pp2_next   = mul_p[HW-1:0];
                state_next = ST_MUL_SUM;
            end
            ST_MUL_SUM: begin
                prod_next  = pp0_reg + {pp1_reg + pp2_reg, HW'(0)};
                state_next = ST_MUL_POP;
            end
            // Line result into the output register
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_payload_next.expr_value    = prod_reg;
                    m_payload_next.running_total = total_reg + prod_reg;
                    m_payload_next.error         = err_reg;
                    total_next                   = total_reg + prod_reg;
                    err_next                     = 1'b0;
                    depth_next                   = '0;
                    state_next                   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Push onto the stack at the current depth
        if (push_req) begin
            if (depth_next == FULL) begin
                err_next = 1'b1;
            end else begin
                ram_we     = 1'b1;
                ram_waddr  = depth_next[AW-1:0];
                ram_wdata  = {push_kind, push_val};
                depth_next = depth_next + DW'(1);
            end
        end

        // Character finished: start the line-end product or wait for the next
        if (char_done) begin
            if (last_next) begin
                prod_next  = VW'(1);
                close_next = 1'b0;
                state_next = ST_MUL_POP;
            end else begin
                state_next = ST_IDLE;
            end
        end

        // Product finished: fold a closed group or report the line
        if (mul_done) begin
            if (close_reg) begin
                if (!mul_paren) begin
                    err_next = 1'b1;
                end
                val_next   = prod_reg;
                state_next = ST_FOLD0;
            end else begin
                if (mul_paren) begin
                    err_next = 1'b1;
                end
                state_next = ST_EMIT;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            err_reg     <= 1'b0;
            total_reg   <= '0;
            last_reg    <= 1'b0;
            close_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            err_reg     <= err_next;
            total_reg   <= total_next;
            last_reg    <= last_next;
            close_reg   <= close_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        val_reg       <= val_next;
        prod_reg      <= prod_next;
        opnd_reg      <= opnd_next;
        pp0_reg       <= pp0_next;
        pp1_reg       <= pp1_next;
        pp2_reg       <= pp2_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Stack depth stays within the RAM
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= FULL)
        else $error("stack depth beyond capacity");

    // A fold that adds into the node below a plus always has such a node
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FOLD2 |-> depth_reg != '0)
        else $error("fold into empty stack");

    // A delivered line leaves an empty stack and a clear error flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && out_free |=>
            depth_reg == '0 && !err_reg && state_reg == ST_IDLE)
        else $error("line end did not reset stack state");

    // The running total in a new result matches the stored total
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && out_free |=>
            m_valid_reg && m_payload_reg.running_total == total_reg)
        else $error("running total mismatch");

    // Multiplier partial products run in a fixed order
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL_P0 |=> state_reg == ST_MUL_P1 ##1 state_reg == ST_MUL_P2)
        else $error("multiply sequence broken");

endmodule

// File: rtl/iee_ram.sv
`timescale 1ns / 1ps

module iee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: tb/tb_infix_expression_evaluator.sv
`timescale 1ns / 1ps

module tb_infix_expression_evaluator;

    localparam int STACK_N     = 64;
    localparam int N_OPS       = 1300;     // acting characters to send
    localparam int LIMIT       = 5000000;  // cycle limit for the whole run
    localparam int DRAIN       = 500;      // cycles after the last result
    localparam int HOLD_AT     = 20;       // results before the long sink stall
    localparam int HOLD_LEN    = 600;
    localparam int QUIET_LO    = 300;      // sender runs gap-free in this window
    localparam int QUIET_HI    = 650;

    // Line evaluator and store of expected line results
    class expr_scoreboard;
        logic [iee_pkg::KIND_W-1:0] node_kind_stk [STACK_N];
        logic [iee_pkg::VAL_W-1:0]  node_val_stk [STACK_N];
        int unsigned                sp;
        logic [iee_pkg::VAL_W-1:0]  grand_total;
        bit                         line_err;
        iee_pkg::out_t              pending_lines[$];
        int                         n_fail;

        function new();
            sp          = 0;
            grand_total = '0;
            line_err    = 1'b0;
            n_fail      = 0;
        endfunction

        function void stack_push(logic [iee_pkg::KIND_W-1:0] k,
                                 logic [iee_pkg::VAL_W-1:0] v);
            if (sp >= STACK_N) begin
                line_err = 1'b1;
            end else begin
                node_kind_stk[sp] = k;
                node_val_stk[sp]  = v;
                sp++;
            end
        endfunction

        // Fold an operand into a pending sum, or push it
        function void fold_operand(logic [iee_pkg::VAL_W-1:0] v);
            logic [iee_pkg::KIND_W-1:0] top;
            if (sp == 0) begin
                stack_push(iee_pkg::KIND_NUM, v);
            end else begin
                top = node_kind_stk[sp-1];
                if (top == iee_pkg::KIND_PAREN || top == iee_pkg::KIND_TIMES) begin
                    stack_push(iee_pkg::KIND_NUM, v);
                end else if (top == iee_pkg::KIND_NUM) begin
                    line_err = 1'b1;
                end else begin
                    sp--;  // drop the pending plus
                    if (sp == 0 || node_kind_stk[sp-1] != iee_pkg::KIND_NUM) begin
                        line_err = 1'b1;
                        stack_push(iee_pkg::KIND_NUM, v);
                    end else begin
                        node_val_stk[sp-1] += v;
                    end
                end
            end
        endfunction

        // Multiply down through the topmost open paren
        function logic [iee_pkg::VAL_W-1:0] collapse_product(output bit met_open);
            logic [iee_pkg::VAL_W-1:0]  prod;
            logic [iee_pkg::KIND_W-1:0] k;
            prod     = iee_pkg::VAL_W'(1);
            met_open = 1'b0;
            while (sp > 0 && !met_open) begin
                sp--;
                k = node_kind_stk[sp];
                if (k == iee_pkg::KIND_PAREN) met_open = 1'b1;
                else if (k == iee_pkg::KIND_NUM) prod = prod * node_val_stk[sp];
                else if (k == iee_pkg::KIND_PLUS) line_err = 1'b1;
            end
            return prod;
        endfunction

        // Apply one accepted character; a line end queues the expected result
        function void apply_char(iee_pkg::in_t it);
            logic [7:0]                c;
            logic [iee_pkg::VAL_W-1:0] g;
            bit                        met;
            iee_pkg::out_t             e;
            c = it.char_code;
            if (c >= iee_pkg::CHAR_ZERO && c <= iee_pkg::CHAR_NINE) begin
                fold_operand({56'd0, c - iee_pkg::CHAR_ZERO});
            end else if (c == iee_pkg::CHAR_PLUS) begin
                stack_push(iee_pkg::KIND_PLUS, '0);
            end else if (c == iee_pkg::CHAR_TIMES) begin
                stack_push(iee_pkg::KIND_TIMES, '0);
            end else if (c == iee_pkg::CHAR_OPEN) begin
                stack_push(iee_pkg::KIND_PAREN, '0);
            end else if (c == iee_pkg::CHAR_CLOSE) begin
                g = collapse_product(met);
                if (!met) line_err = 1'b1;
                fold_operand(g);
            end
            if (it.end_of_expression) begin
                g = collapse_product(met);
                if (met) line_err = 1'b1;
                sp          = 0;
                grand_total = grand_total + g;
                e.expr_value    = g;
                e.running_total = grand_total;
                e.error         = line_err;
                pending_lines.push_back(e);
                line_err = 1'b0;
            end
        endfunction

        task report(string msg);
            n_fail++;
            $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task check_result(iee_pkg::out_t got);
            iee_pkg::out_t want;
            if (pending_lines.size() == 0) begin
                report($sformatf("result with nothing expected, value %h", got.expr_value));
            end else begin
                want = pending_lines.pop_front();
                if (got.expr_value !== want.expr_value)
                    report($sformatf("expr_value got %h expected %h",
                                     got.expr_value, want.expr_value));
                if (got.running_total !== want.running_total)
                    report($sformatf("running_total got %h expected %h",
                                     got.running_total, want.running_total));
                if (got.error !== want.error)
                    report($sformatf("error got %b expected %b", got.error, want.error));
            end
        endtask
    endclass

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    iee_pkg::in_t   s_payload;
    logic           m_valid;
    logic           m_ready;
    iee_pkg::out_t  m_payload;

    expr_scoreboard sb;
    iee_pkg::in_t   line_q[$];
    int             chars_sent;
    int             ops_sent;
    int             cycle_cnt = 0;

    infix_expression_evaluator #(
        .STACK_DEPTH(STACK_N)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Cycle limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit is_acting(logic [7:0] c);
        return (c >= iee_pkg::CHAR_ZERO && c <= iee_pkg::CHAR_NINE) ||
               c == iee_pkg::CHAR_PLUS || c == iee_pkg::CHAR_TIMES ||
               c == iee_pkg::CHAR_OPEN || c == iee_pkg::CHAR_CLOSE;
    endfunction

    function automatic logic [7:0] pick_ignored();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_acting(c)) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] digit_char(int lo);
        return iee_pkg::CHAR_ZERO + 8'($urandom_range(lo, 9));
    endfunction

    // One input transfer; gaps follow at random outside the quiet window
    task automatic send_item(iee_pkg::in_t it);
        int gap;
        gap = 0;
        s_valid   <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.apply_char(it);
        chars_sent++;
        if (is_acting(it.char_code)) ops_sent++;
        if (chars_sent < QUIET_LO || chars_sent > QUIET_HI)
            while ($urandom_range(0, 99) < 10) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic queue_char(logic [7:0] c);
        iee_pkg::in_t it;
        it.char_code         = c;
        it.end_of_expression = 1'b0;
        line_q.push_back(it);
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    endtask

    // Mark the last character as line end and send the line
    task automatic flush_line();
        if (line_q.size() == 0) queue_char(pick_ignored());
        line_q[line_q.size()-1].end_of_expression = 1'b1;
        foreach (line_q[i]) send_item(line_q[i]);
        line_q.delete();
    endtask

    // Well-formed expression with random nesting and operators
    task automatic gen_wellformed(int max_tok, int lo_digit);
        int open_n;
        int n;
        bit want_operand;
        int r;
        open_n       = 0;
        n            = 0;
        want_operand = 1'b1;
        forever begin
            if (want_operand) begin
                if (open_n < 6 && n < max_tok && $urandom_range(0, 3) == 0) begin
                    queue_char(iee_pkg::CHAR_OPEN);
                    open_n++;
                end else begin
                    queue_char(digit_char(lo_digit));
                    want_operand = 1'b0;
                end
            end else if (n >= max_tok) begin
                if (open_n == 0) break;
                queue_char(iee_pkg::CHAR_CLOSE);
                open_n--;
            end else begin
                r = $urandom_range(0, 9);
                if (r < 2 && open_n > 0) begin
                    queue_char(iee_pkg::CHAR_CLOSE);
                    open_n--;
                end else begin
                    queue_char(r < 6 ? iee_pkg::CHAR_PLUS : iee_pkg::CHAR_TIMES);
                    want_operand = 1'b1;
                end
            end
            n++;
            if ($urandom_range(0, 49) == 0) queue_char(pick_ignored());
        end
    endtask

    // Random acting characters in any order
    task automatic gen_broken();
        int n;
        int r;
        n = $urandom_range(1, 12);
        repeat (n) begin
            r = $urandom_range(0, 5);
            case (r)
                0: queue_char(iee_pkg::CHAR_PLUS);
                1: queue_char(iee_pkg::CHAR_TIMES);
                2: queue_char(iee_pkg::CHAR_OPEN);
                3: queue_char(iee_pkg::CHAR_CLOSE);
                default: queue_char(digit_char(0));
            endcase
        end
    endtask

    // Random bytes of any code
    task automatic gen_noise();
        repeat ($urandom_range(1, 8)) queue_char(8'($urandom_range(0, 255)));
    endtask

    // Lines deep enough to come near to or overflow the stack
    task automatic gen_deep();
        int k;
        if ($urandom_range(0, 1)) begin
            k = $urandom_range(60, 70);
            repeat (k) queue_char(iee_pkg::CHAR_OPEN);
        end else begin
            k = $urandom_range(30, 36);
            repeat (k) begin
                queue_char(digit_char(7));
                queue_char(iee_pkg::CHAR_TIMES);
            end
        end
        repeat ($urandom_range(0, 2)) queue_char(iee_pkg::CHAR_CLOSE);
    endtask

    // Result sink with random stalls and one long hold-off
    initial begin : result_sink
        int results_seen;
        int hold_left;
        bit held;
        results_seen = 0;
        hold_left    = 0;
        held         = 1'b0;
        m_ready      = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_payload);
                results_seen++;
            end
            if (!held && results_seen >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (results_seen >= 40 && results_seen < 90) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // Reset, stimulus and end of run
    initial begin : stimulus
        int  r;
        bit  first;
        sb         = new();
        chars_sent = 0;
        ops_sent   = 0;
        first      = 1'b1;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_payload  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lines: extremes, every operator and the error cases
        queue_text("9+0*(7)");
        flush_line();
        queue_char(8'hFF);          // empty line, value is one
        flush_line();
        queue_text("+5");           // plus with nothing below
        flush_line();
        queue_text("(+3)");         // plus above an open paren
        flush_line();
        queue_text("12");           // two numbers in a row
        flush_line();
        queue_text("2*+");          // plus and times left at line end
        flush_line();
        queue_text("4)");           // close without open
        flush_line();
        queue_text("(5");           // paren left open at line end
        flush_line();
        queue_text("7");
        queue_char(8'h00);          // line end on an ignored code
        flush_line();

        // Random lines, mostly well formed
        while (ops_sent < N_OPS) begin
            r = $urandom_range(0, 99);
            if (first || r < 3) gen_deep();
            else if (r < 13) gen_broken();
            else if (r < 18) gen_noise();
            else if (r < 26) gen_wellformed($urandom_range(20, 50),
                                            $urandom_range(0, 1) ? 6 : 0);
            else gen_wellformed($urandom_range(1, 15), 0);
            first = 1'b0;
            flush_line();
        end
        s_valid <= 1'b0;

        while (sb.pending_lines.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.n_fail == 0 && sb.pending_lines.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/iee_pkg.sv
rtl/iee_ram.sv
rtl/infix_expression_evaluator.sv
tb/tb_infix_expression_evaluator.sv
